// File: hw/rtl/nbw_pkg.sv
`timescale 1ns / 1ps

package nbw_pkg;

    // geometry limits of the line store and the row counter
    localparam int NBW_MAX_COLS = 2048;
    localparam int NBW_MAX_ROWS = 4096;

    // neighbour order, also the order of the weights in a result beat
    localparam int NUM_NB      = 4;
    localparam int NB_LEFT     = 0;
    localparam int NB_UP_LEFT  = 1;
    localparam int NB_UP       = 2;
    localparam int NB_UP_RIGHT = 3;

    localparam int PIX_W = 24;
    localparam int WGT_W = 24;
    localparam int G_W   = 33;

    // exponential lane: distance, beta product, series steps, final add,
    // squarings, rounding, gamma product
    localparam int SERIES_STEPS = 11;
    localparam int SQUARINGS    = 5;
    localparam int LANE_LAT     = 2 + 3 * SERIES_STEPS + 1 + SQUARINGS + 2;

    // front register, lane, two scaling stages, output register and skid
    localparam int FLIGHT_MAX = 1 + LANE_LAT + 2 + 2;

    // register reset values
    localparam logic [23:0] BETA_RESET   = 24'd0;
    localparam logic [15:0] GAMMA_RESET  = 16'd12800;
    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    // exp(-x) is taken as zero from x = 17.0 on (upper bits of the Q.24 product)
    localparam logic [17:0] X_LIMIT_HI    = 18'd17;
    localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
    localparam logic [30:0] E_ROUND       = 31'd8192;
    localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

    typedef enum logic [1:0] {
        CFG_BETA   = 2'd0,
        CFG_GAMMA  = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } cfg_index_t;

    // one pixel and one of its neighbours, as handed to an exponential lane
    typedef struct packed {
        logic             valid;
        logic             present;
        logic [PIX_W-1:0] pix_a;
        logic [PIX_W-1:0] pix_b;
    } nb_pair_t;

    // context carried through the series and squaring stages
    typedef struct packed {
        logic        valid;
        logic        present;
        logic        zero;
        logic [29:0] y;
        logic [30:0] s;
        logic [29:0] val;
        logic [29:0] aux;
    } series_ctx_t;

    // one result beat
    typedef struct packed {
        logic                          last;
        logic [NUM_NB-1:0][WGT_W-1:0]  w;
    } result_t;

    // floor(2^32 / k) for the series divisors
    function automatic logic [31:0] recip_q32(input int k);
        logic [31:0] r;
        begin
            case (k)
                2:       r = 32'h8000_0000;
                3:       r = 32'h5555_5555;
                4:       r = 32'h4000_0000;
                5:       r = 32'h3333_3333;
                6:       r = 32'h2AAA_AAAA;
                7:       r = 32'h2492_4924;
                8:       r = 32'h2000_0000;
                9:       r = 32'h1C71_C71C;
                10:      r = 32'h1999_9999;
                11:      r = 32'h1745_D174;
                12:      r = 32'h1555_5555;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // clamp a rounded weight to 24 bits
    function automatic logic [WGT_W-1:0] sat24(input logic [25:0] v);
        logic [WGT_W-1:0] r;
        begin
            if (|v[25:24])
                r = {WGT_W{1'b1}};
            else
                r = v[WGT_W-1:0];
            return r;
        end
    endfunction

endpackage

// File: hw/rtl/nbw_line_front.sv
`timescale 1ns / 1ps

module nbw_line_front
    import nbw_pkg::*;
#(
    parameter int MAX_COLS = NBW_MAX_COLS,
    parameter int MAX_ROWS = NBW_MAX_ROWS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         accept,
    input  logic [PIX_W-1:0]             pix,
    input  logic [11:0]                  image_width,
    input  logic [12:0]                  image_height,
    output nb_pair_t [NUM_NB-1:0]        pairs,
    output logic                         frame_end
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WW    = ($clog2(MAX_COLS + 1) > 12) ? $clog2(MAX_COLS + 1) : 12;
    localparam int HW    = ($clog2(MAX_ROWS + 1) > 13) ? $clog2(MAX_ROWS + 1) : 13;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] diag_hold_reg;

    logic [WW-1:0]    w_eff, col_inc;
    logic [HW-1:0]    h_eff, row_inc;
    logic [COL_W-1:0] col_upr;
    logic             row_end, frame_last;

    // line store
    logic [PIX_W-1:0] line_mem [MAX_COLS];
    logic [PIX_W-1:0] up_rd_reg, upr_rd_reg;

    // first stage
    logic             v1_reg;
    logic [PIX_W-1:0] pix1_reg, left1_reg;
    logic             col_first1_reg, row_first1_reg, upr_ok1_reg, fe1_reg;

    // geometry in use, clamped into range
    always_comb
    begin
        if (image_width == 12'd0)
            w_eff = WW'(1);
        else if (WW'(image_width) > WW'(MAX_COLS))
            w_eff = WW'(MAX_COLS);
        else
            w_eff = WW'(image_width);

        if (image_height == 13'd0)
            h_eff = HW'(1);
        else if (HW'(image_height) > HW'(MAX_ROWS))
            h_eff = HW'(MAX_ROWS);
        else
            h_eff = HW'(image_height);
    end

    // row and frame ends
    assign col_inc    = WW'(col_reg) + WW'(1);
    assign row_inc    = HW'(row_reg) + HW'(1);
    assign row_end    = (col_inc >= w_eff);
    assign frame_last = row_end && (row_inc >= h_eff);
    assign col_upr    = col_reg + COL_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_last ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    // counters, left pixel, stage valid and up-left hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            v1_reg        <= 1'b0;
            diag_hold_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                left_reg <= pix;
            end
            if (en)
                v1_reg <= accept;
            if (en && v1_reg)
                diag_hold_reg <= up_rd_reg;
        end
    end

    // line store: read above and above-right, then overwrite above
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg         <= line_mem[col_reg];
            upr_rd_reg        <= line_mem[col_upr];
            line_mem[col_reg] <= pix;
        end
    end

    // first stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg       <= pix;
            left1_reg      <= left_reg;
            col_first1_reg <= (col_reg == '0);
            row_first1_reg <= (row_reg == '0);
            upr_ok1_reg    <= !row_end;
            fe1_reg        <= frame_last;
        end
    end

    // neighbour pairs with border masks
    always_comb
    begin
        for (int n = 0; n < NUM_NB; n++)
        begin
            pairs[n].valid = v1_reg;
            pairs[n].pix_a = pix1_reg;
        end
        pairs[NB_LEFT].present     = !col_first1_reg;
        pairs[NB_LEFT].pix_b       = left1_reg;
        pairs[NB_UP_LEFT].present  = !col_first1_reg && !row_first1_reg;
        pairs[NB_UP_LEFT].pix_b    = diag_hold_reg;
        pairs[NB_UP].present       = !row_first1_reg;
        pairs[NB_UP].pix_b         = up_rd_reg;
        pairs[NB_UP_RIGHT].present = !row_first1_reg && upr_ok1_reg;
        pairs[NB_UP_RIGHT].pix_b   = upr_rd_reg;
    end

    assign frame_end = fe1_reg;

endmodule

// File: hw/rtl/nbw_exp_lane.sv
`timescale 1ns / 1ps

module nbw_exp_lane
    import nbw_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  nb_pair_t       pair,
    input  logic [23:0]    beta,
    input  logic [15:0]    gamma,
    output logic           g_valid,
    output logic [G_W-1:0] g
);

    // squared colour distance
    logic [7:0]  ca, cb, ad;
    logic [15:0] sq;
    logic [17:0] d_sum;
    logic        l1_valid_reg, l1_present_reg;
    logic [17:0] l1_d_reg;

    always_comb
    begin
        d_sum = '0;
        ca    = '0;
        cb    = '0;
        ad    = '0;
        sq    = '0;
        for (int c = 0; c < 3; c++)
        begin
            ca    = pair.pix_a[8*c +: 8];
            cb    = pair.pix_b[8*c +: 8];
            ad    = (ca > cb) ? ca - cb : cb - ca;
            sq    = ad * ad;
            d_sum = d_sum + {2'b00, sq};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg   <= 1'b0;
            l1_present_reg <= 1'b0;
            l1_d_reg       <= '0;
        end
        else if (en)
        begin
            l1_valid_reg   <= pair.valid;
            l1_present_reg <= pair.present;
            l1_d_reg       <= d_sum;
        end
    end

    // beta product, limit check, series seed
    logic [41:0] x;
    series_ctx_t l2_next, l2_reg;

    always_comb
    begin
        x               = beta * l1_d_reg;
        l2_next.valid   = l1_valid_reg;
        l2_next.present = l1_present_reg;
        l2_next.zero    = (x[41:24] >= X_LIMIT_HI);
        l2_next.y       = {x[28:0], 1'b0};
        l2_next.s       = Q30_ONE;
        l2_next.val     = {x[28:0], 1'b0};
        l2_next.aux     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l2_reg <= '0;
        else if (en)
            l2_reg <= l2_next;
    end

    // taylor series, three stages per term: product, reciprocal, correction
    series_ctx_t a_reg [SERIES_STEPS];
    series_ctx_t b_reg [SERIES_STEPS];
    series_ctx_t c_reg [SERIES_STEPS];

    for (genvar i = 0; i < SERIES_STEPS; i++)
    begin : g_step
        localparam int          K     = i + 2;
        localparam logic [31:0] RECIP = recip_q32(K);
        localparam logic [29:0] K_W   = 30'(K);
        localparam bit          SUB   = ((K % 2) == 0);

        series_ctx_t src, a_next, b_next, c_next;
        logic [59:0] ty_prod;
        logic [61:0] rq_prod;
        logic [29:0] rem;

        if (i == 0)
        begin : g_first
            assign src = l2_reg;
        end
        else
        begin : g_chain
            assign src = c_reg[i-1];
        end

        always_comb
        begin
            // term * y, and fold the previous term into the sum
            a_next     = src;
            ty_prod    = src.val * src.y;
            a_next.val = ty_prod[59:30];
            if (SUB)
                a_next.s = src.s - {1'b0, src.val};
            else
                a_next.s = src.s + {1'b0, src.val};

            // quotient estimate, at most one below
            b_next     = a_reg[i];
            rq_prod    = a_reg[i].val * RECIP;
            b_next.val = rq_prod[61:32];
            b_next.aux = a_reg[i].val;

            // remainder check
            c_next     = b_reg[i];
            rem        = b_reg[i].aux - b_reg[i].val * K_W;
            c_next.val = (rem >= K_W) ? b_reg[i].val + 30'd1 : b_reg[i].val;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_reg[i] <= '0;
                b_reg[i] <= '0;
                c_reg[i] <= '0;
            end
            else if (en)
            begin
                a_reg[i] <= a_next;
                b_reg[i] <= b_next;
                c_reg[i] <= c_next;
            end
        end
    end

    // last term is added
    series_ctx_t fin_next, fin_reg;

    always_comb
    begin
        fin_next   = c_reg[SERIES_STEPS-1];
        fin_next.s = c_reg[SERIES_STEPS-1].s + {1'b0, c_reg[SERIES_STEPS-1].val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_reg <= '0;
        else if (en)
            fin_reg <= fin_next;
    end

    // repeated squaring, exp(-x) = exp(-x/32)^32
    series_ctx_t sq_reg [SQUARINGS];

    for (genvar j = 0; j < SQUARINGS; j++)
    begin : g_square
        series_ctx_t src, sq_next;
        logic [61:0] ss_prod;

        if (j == 0)
        begin : g_first
            assign src = fin_reg;
        end
        else
        begin : g_chain
            assign src = sq_reg[j-1];
        end

        always_comb
        begin
            sq_next   = src;
            ss_prod   = src.s * src.s;
            sq_next.s = ss_prod[60:30];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_reg[j] <= '0;
            else if (en)
                sq_reg[j] <= sq_next;
        end
    end

    // round to Q1.16
    logic [30:0] e_sum;
    logic        e_valid_reg, e_present_reg;
    logic [16:0] e_reg;

    assign e_sum = sq_reg[SQUARINGS-1].s + E_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            e_present_reg <= 1'b0;
            e_reg         <= '0;
        end
        else if (en)
        begin
            e_valid_reg   <= sq_reg[SQUARINGS-1].valid;
            e_present_reg <= sq_reg[SQUARINGS-1].present;
            e_reg         <= sq_reg[SQUARINGS-1].zero ? 17'd0 : e_sum[30:14];
        end
    end

    // gamma product, zero where the neighbour is outside the image
    logic [G_W-1:0] g_next, g_reg;
    logic           g_valid_reg;

    always_comb
    begin
        if (e_present_reg)
            g_next = gamma * e_reg;
        else
            g_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            g_reg       <= '0;
        end
        else if (en)
        begin
            g_valid_reg <= e_valid_reg;
            g_reg       <= g_next;
        end
    end

    assign g_valid = g_valid_reg;
    assign g       = g_reg;

endmodule

// File: hw/rtl/nbw_out_stage.sv
`timescale 1ns / 1ps

module nbw_out_stage
    import nbw_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [NUM_NB-1:0][G_W-1:0]       g,
    input  logic                             in_last,
    output logic                             en,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [NUM_NB*WGT_W-1:0]          m_axis_tdata,
    output logic                             m_axis_tlast
);

    // straight lanes are even, diagonal lanes odd
    localparam int HALF = NUM_NB / 2;

    logic                   w1_valid_reg, w1_last_reg;
    logic [WGT_W-1:0]       w1_straight_reg [HALF];
    logic [48:0]            w1_prod_reg [HALF];
    logic [33:0]            st_sum [HALF];
    logic [48:0]            dg_prod [HALF];

    logic                   w2_valid_reg;
    result_t                w2_reg;
    logic [49:0]            dg_sum [HALF];

    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    logic                   skid_valid_reg, skid_valid_next;
    result_t                skid_reg, skid_next;
    logic                   pop, incoming;

    assign en = !skid_valid_reg;

    // straight rounding, diagonal scale product
    always_comb
    begin
        for (int j = 0; j < HALF; j++)
        begin
            st_sum[j]  = {1'b0, g[2*j]} + 34'd128;
            dg_prod[j] = g[2*j+1] * INV_SQRT2_Q16;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_valid_reg <= 1'b0;
            w2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            w1_valid_reg <= in_valid;
            w2_valid_reg <= w1_valid_reg;
        end
    end

    // diagonal rounding
    always_comb
    begin
        for (int j = 0; j < HALF; j++)
            dg_sum[j] = {1'b0, w1_prod_reg[j]} + 50'd8388608;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_last_reg <= in_last;
            w2_reg.last <= w1_last_reg;
            for (int j = 0; j < HALF; j++)
            begin
                w1_straight_reg[j] <= sat24(st_sum[j][33:8]);
                w1_prod_reg[j]     <= dg_prod[j];
                w2_reg.w[2*j]      <= w1_straight_reg[j];
                w2_reg.w[2*j+1]    <= sat24(dg_sum[j][49:24]);
            end
        end
    end

    // output register with skid entry
    assign pop      = out_valid_reg && m_axis_tready;
    assign incoming = en && w2_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (incoming)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_next       = w2_reg;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = w2_reg;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.w;
    assign m_axis_tlast  = out_reg.last;

endmodule

// File: hw/rtl/neighbour_edge_weights_unit.sv
`timescale 1ns / 1ps
// channel   direction  beat contents
// s_axis    in         tdata[23:0]: red, green, blue (8 bit each, lowest first)
// m_axis    out        tdata[95:0]: left, up_left, up, up_right weights (Q8.16);
//                      tlast: frame_end
// cfg       in         cfg_we, cfg_addr (0 beta, 1 gamma, 2 width, 3 height), cfg_wdata
//
// one pixel per cycle while s_axis_tready is high; on its way to the output a pixel
// passes the eleven three-stage series terms and the five squarings of each lane
// reset clears counters, left pixel, up-left hold and all valid bits; the line
// store is not cleared and holds no data until a row has been written
// a stalled output fills one skid entry, then s_axis_tready drops and the whole
// pipeline holds; up to 48 pixels may be in flight

module neighbour_edge_weights_unit
    import nbw_pkg::*;
#(
    parameter int MAX_COLS = NBW_MAX_COLS,
    parameter int MAX_ROWS = NBW_MAX_ROWS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [PIX_W-1:0]          s_axis_tdata,   // red, green, blue
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [NUM_NB*WGT_W-1:0]   m_axis_tdata,   // left, up_left, up, up_right
    output logic                      m_axis_tlast,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_addr,
    input  logic [23:0]               cfg_wdata
);

    logic [23:0] beta_reg;
    logic [15:0] gamma_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    logic                         en, accept;
    nb_pair_t [NUM_NB-1:0]        pairs;
    logic                         front_fe;
    logic [NUM_NB-1:0]            lane_valid;
    logic [NUM_NB-1:0][G_W-1:0]   lane_g;
    logic                         fe_line_reg [LANE_LAT];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg   <= BETA_RESET;
            gamma_reg  <= GAMMA_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_BETA:   beta_reg   <= cfg_wdata;
                CFG_GAMMA:  gamma_reg  <= cfg_wdata[15:0];
                CFG_WIDTH:  width_reg  <= cfg_wdata[11:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[12:0];
                default:    ;
            endcase
        end
    end

    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    // counters, line store and neighbour selection
    nbw_line_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .accept       (accept),
        .pix          (s_axis_tdata),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pairs        (pairs),
        .frame_end    (front_fe)
    );

    // one exponential lane per neighbour
    for (genvar n = 0; n < NUM_NB; n++)
    begin : g_lane
        nbw_exp_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .pair    (pairs[n]),
            .beta    (beta_reg),
            .gamma   (gamma_reg),
            .g_valid (lane_valid[n]),
            .g       (lane_g[n])
        );
    end

    // frame end travels beside the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fe_line_reg[0] <= front_fe;
            for (int i = 1; i < LANE_LAT; i++)
                fe_line_reg[i] <= fe_line_reg[i-1];
        end
    end

    // scaling, saturation and output buffering
    nbw_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (&lane_valid),
        .g             (lane_g),
        .in_last       (fe_line_reg[LANE_LAT-1]),
        .en            (en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: hw/rtl/nbw_checker.sv
`timescale 1ns / 1ps

module nbw_checker
    import nbw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [NUM_NB*WGT_W-1:0]   m_axis_tdata,
    input  logic                      m_axis_tlast
);

    localparam int CNT_W = $clog2(FLIGHT_MAX + 1) + 1;

    logic [CNT_W-1:0] flight_reg, flight_next;
    logic             in_beat, out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // pixels taken but not yet delivered
    always_comb
    begin
        flight_next = flight_reg;
        if (in_beat && !out_beat)
            flight_next = flight_reg + CNT_W'(1);
        else if (out_beat && !in_beat)
            flight_next = flight_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else
            flight_reg <= flight_next;
    end

    // input backpressure only while a result is waiting
    a_ready_low_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // pipeline never holds more than its registers
    a_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= CNT_W'(FLIGHT_MAX))
        else $error("more pixels in flight than pipeline depth");

    // no result without a pixel behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> flight_reg != '0)
        else $error("result offered with no pixel in flight");

endmodule

bind neighbour_edge_weights_unit nbw_checker u_nbw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
